// File: rtl/crc8_register_frame_receiver_assert.svh
// Assertion macros used by the checker file.
`ifndef CRC8_REGISTER_FRAME_RECEIVER_ASSERT_SVH
`define CRC8_REGISTER_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRC8RFR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRC8RFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/crc8rfr_pkg.sv
package crc8rfr_pkg;

  localparam int MAX_PACKET_BYTES_DEFAULT = 64;

  localparam logic [7:0] HEAD_A    = 8'h55;
  localparam logic [7:0] HEAD_B    = 8'hAA;
  localparam logic [7:0] CMD_READ  = 8'h01;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CRC_POLY  = 8'h07;

  localparam logic [3:0] FRAME_BYTES  = 4'd10;
  localparam logic [3:0] BYTE_HEAD_A  = 4'd0;
  localparam logic [3:0] BYTE_HEAD_B  = 4'd1;
  localparam logic [3:0] BYTE_CMD     = 4'd2;
  localparam logic [3:0] BYTE_ADDR_LO = 4'd4;
  localparam logic [3:0] BYTE_CRC     = FRAME_BYTES - 4'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic        is_write;
    logic [15:0] register_address;
    logic [31:0] data_value;
  } out_item_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/crc8rfr_in_stage.sv
module crc8rfr_in_stage
  import crc8rfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     rx_valid,
  output logic     rx_ready,
  input  in_item_t rx_data,
  input  logic     advance,
  output logic     step,
  output in_item_t item
);

  logic ir_valid;

  assign rx_ready = !rst && (!ir_valid || advance);
  assign step     = ir_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      item <= rx_data;
    end
  end

endmodule

// File: rtl/crc8rfr_parser.sv
module crc8rfr_parser
  import crc8rfr_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

  logic [CW-1:0] count, count_next, count_eff;
  logic [3:0]    index, index_next, index_eff;
  logic          header_good, header_good_next, header_good_eff;
  logic [7:0]    crc, crc_next, crc_eff;
  logic [7:0]    command, command_next, command_eff;
  logic [15:0]   address, address_next, address_eff;
  logic [31:0]   value, value_next, value_eff;
  logic [7:0]    b;

  assign b = item.rx_byte;

  always_comb begin
    if (item.packet_start) begin
      count_eff       = '0;
      index_eff       = '0;
      header_good_eff = 1'b1;
      crc_eff         = '0;
      command_eff     = '0;
      address_eff     = '0;
      value_eff       = '0;
    end else begin
      count_eff       = count;
      index_eff       = index;
      header_good_eff = header_good;
      crc_eff         = crc;
      command_eff     = command;
      address_eff     = address;
      value_eff       = value;
    end

    count_next       = count_eff;
    index_next       = index_eff;
    header_good_next = header_good_eff;
    crc_next         = crc_eff;
    command_next     = command_eff;
    address_next     = address_eff;
    value_next       = value_eff;
    res_valid        = 1'b0;

    res.is_write         = (command_eff == CMD_WRITE);
    res.register_address = address_eff;
    res.data_value       = value_eff;

    if (count_eff < CW'(MAX_PACKET_BYTES)) begin
      count_next = count_eff + CW'(1);
      if (index_eff >= BYTE_CRC) begin
        res_valid = header_good_eff && (crc_eff == b) &&
                    (command_eff == CMD_READ || command_eff == CMD_WRITE);
        index_next       = '0;
        header_good_next = 1'b1;
        crc_next         = '0;
        command_next     = '0;
        address_next     = '0;
        value_next       = '0;
      end else begin
        priority if (index_eff == BYTE_HEAD_A) begin
          header_good_next = (b == HEAD_A);
        end else if (index_eff == BYTE_HEAD_B) begin
          header_good_next = header_good_eff && (b == HEAD_B);
        end else if (index_eff == BYTE_CMD) begin
          command_next = b;
        end else if (index_eff <= BYTE_ADDR_LO) begin
          address_next = {address_eff[7:0], b};
        end else begin
          value_next = {value_eff[23:0], b};
        end
        crc_next   = crc8_update(crc_eff, b);
        index_next = index_eff + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      index       <= '0;
      header_good <= 1'b1;
      crc         <= '0;
      command     <= '0;
      address     <= '0;
      value       <= '0;
    end else if (step) begin
      count       <= count_next;
      index       <= index_next;
      header_good <= header_good_next;
      crc         <= crc_next;
      command     <= command_next;
      address     <= address_next;
      value       <= value_next;
    end
  end

endmodule

// File: rtl/crc8rfr_out_stage.sv
module crc8rfr_out_stage
  import crc8rfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      res_valid,
  input  out_item_t res,
  output logic      advance,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp_data
);

  assign advance = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && res_valid) begin
      rsp_data <= res;
    end
  end

endmodule

// File: rtl/crc8_register_frame_receiver.sv
// A frame's request is registered in the output stage from its CRC byte held in the input register.
// Throughput: one byte per cycle; only reset or a stalled request register holds up input.
// The CRC-8 update and frame decode fit between the input and request registers.
// Reset (rst, synchronous) clears both registers' valid flags and restarts the packet framing.
module crc8_register_frame_receiver
  import crc8rfr_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      rx_valid,
  output logic      rx_ready,
  input  in_item_t  rx_data,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp_data
);

  logic      advance;
  logic      step;
  in_item_t  item;
  logic      res_valid;
  out_item_t res;

  crc8rfr_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_data  (rx_data),
    .advance  (advance),
    .step     (step),
    .item     (item)
  );

  crc8rfr_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  crc8rfr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

// File: rtl/crc8rfr_checker.sv
`include "crc8_register_frame_receiver_assert.svh"

module crc8rfr_checker
  import crc8rfr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      rx_valid,
  input logic      rx_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input out_item_t rsp_data
);

  `CRC8RFR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `CRC8RFR_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_data))
  `CRC8RFR_ASSERT_NOW(a_ready_when_free, clk, rst, !rsp_valid || rsp_ready, rx_ready)
  `CRC8RFR_ASSERT_NOW(a_rsp_from_byte, clk, rst, $rose(rsp_valid), $past(rx_valid && rx_ready, 2))

endmodule

bind crc8_register_frame_receiver crc8rfr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_valid  (rx_valid),
  .rx_ready  (rx_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);
